// ===== rtl/ccd_pkg.sv =====
`default_nettype none

package ccd_pkg;

  localparam int unsigned Channels       = 6;
  localparam int unsigned QueueDepth     = 2;
  localparam int unsigned DivSteps       = 16;

  localparam logic [7:0]  LevelBase      = 8'd180;
  localparam logic [7:0]  Term           = 8'h0a;
  localparam logic [7:0]  Digit0         = 8'h30;
  localparam logic [7:0]  SwitchOp       = 8'haa;
  localparam logic [7:0]  FreqStep       = 8'h10;
  localparam logic [7:0]  FreqLast       = 8'h60;
  localparam logic [7:0]  SubAllOff      = 8'haa;
  localparam logic [15:0] NumeratorReset = 16'd10000;
  localparam logic [15:0] PeriodMax      = 16'hffff;
  localparam logic [15:0] FreqDefault    = 16'd1;
  localparam logic [15:0] FreqThousand   = 16'd1000;
  localparam logic [5:0]  AllPins        = 6'h3f;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_LEVEL,
    KIND_CH_OFF,
    KIND_CH_ON,
    KIND_ALL_OFF,
    KIND_FREQ_ZERO,
    KIND_FREQ
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [2:0]  chan;
    logic [7:0]  pot_value;
    logic [15:0] freq;
  } cmd_t;

  typedef struct packed {
    logic [5:0]  pin_levels;
    logic [5:0]  timer_running;
    logic        frequency_mode;
    logic        pot_write;
    logic [2:0]  pot_channel;
    logic [7:0]  pot_value;
    logic        period_write;
    logic [2:0]  period_channel;
    logic [15:0] period_value;
    logic [5:0]  counter_clear;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/ccd_cmd_if.sv =====
`default_nettype none

interface ccd_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] operation;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic [7:0] byte4;
  logic [7:0] byte5;

  modport source (output valid, operation, byte1, byte2, byte3, byte4, byte5, input ready);
  modport sink   (input valid, operation, byte1, byte2, byte3, byte4, byte5, output ready);
endinterface

`default_nettype wire

// ===== rtl/ccd_res_if.sv =====
`default_nettype none

interface ccd_res_if;
  logic        valid;
  logic        ready;
  logic [5:0]  pin_levels;
  logic [5:0]  timer_running;
  logic        frequency_mode;
  logic        pot_write;
  logic [2:0]  pot_channel;
  logic [7:0]  pot_value;
  logic        period_write;
  logic [2:0]  period_channel;
  logic [15:0] period_value;
  logic [5:0]  counter_clear;

  modport source (output valid, pin_levels, timer_running, frequency_mode, pot_write,
                  pot_channel, pot_value, period_write, period_channel, period_value,
                  counter_clear, input ready);
  modport sink   (input valid, pin_levels, timer_running, frequency_mode, pot_write,
                  pot_channel, pot_value, period_write, period_channel, period_value,
                  counter_clear, output ready);
endinterface

`default_nettype wire

// ===== rtl/ccd_front.sv =====
`default_nettype none

module ccd_front #(
  parameter int unsigned CHANNELS = ccd_pkg::Channels
) (
  ccd_cmd_if.sink        cmd,
  input  wire logic      full_i,
  output ccd_pkg::cmd_t  cmd_o,
  output logic           push_o
);

  logic [15:0] d1, d2, d3;
  logic [2:0]  chan;
  logic [7:0]  op;

  assign op     = cmd.operation;
  assign cmd.ready = !full_i;
  assign push_o = cmd.valid && !full_i;

  assign d1 = {8'h00, cmd.byte1} - {8'h00, ccd_pkg::Digit0};
  assign d2 = {8'h00, cmd.byte2} - {8'h00, ccd_pkg::Digit0};
  assign d3 = {8'h00, cmd.byte3} - {8'h00, ccd_pkg::Digit0};

  always_comb begin
    cmd_o.kind      = ccd_pkg::KIND_NONE;
    cmd_o.chan      = '0;
    cmd_o.pot_value = ccd_pkg::LevelBase - {cmd.byte1[6:0], 1'b0};
    cmd_o.freq      = ccd_pkg::FreqDefault;
    chan            = '0;
    case (op) inside
      [8'h01:8'h06]: begin
        chan = 3'(op - 8'd1);
        if (32'(chan) < CHANNELS) begin
          cmd_o.kind = ccd_pkg::KIND_LEVEL;
          cmd_o.chan = chan;
        end
      end
      ccd_pkg::SwitchOp: begin
        case (cmd.byte1) inside
          [8'h01:8'h06]: begin
            chan = 3'(cmd.byte1 - 8'h01);
            if (32'(chan) < CHANNELS) begin
              cmd_o.kind = ccd_pkg::KIND_CH_OFF;
              cmd_o.chan = chan;
            end
          end
          [8'ha1:8'ha6]: begin
            chan = 3'(cmd.byte1 - 8'ha1);
            if (32'(chan) < CHANNELS) begin
              cmd_o.kind = ccd_pkg::KIND_CH_ON;
              cmd_o.chan = chan;
            end
          end
          ccd_pkg::SubAllOff: begin
            cmd_o.kind = ccd_pkg::KIND_ALL_OFF;
          end
          default: begin
            cmd_o.kind = ccd_pkg::KIND_NONE;
          end
        endcase
      end
      default: begin
        if (op[3:0] == 4'h0 && op >= ccd_pkg::FreqStep && op <= ccd_pkg::FreqLast) begin
          chan = op[6:4] - 3'd1;
          if (32'(chan) < CHANNELS) begin
            cmd_o.chan = chan;
            if (cmd.byte1 == ccd_pkg::Digit0) begin
              cmd_o.kind = ccd_pkg::KIND_FREQ_ZERO;
            end else begin
              cmd_o.kind = ccd_pkg::KIND_FREQ;
              if (cmd.byte2 == ccd_pkg::Term) begin
                cmd_o.freq = d1;
              end else if (cmd.byte3 == ccd_pkg::Term) begin
                cmd_o.freq = 16'(d1 * 16'd10) + d2;
              end else if (cmd.byte4 == ccd_pkg::Term) begin
                cmd_o.freq = 16'(d1 * 16'd100) + 16'(d2 * 16'd10) + d3;
              end else if (cmd.byte5 == ccd_pkg::Term) begin
                cmd_o.freq = ccd_pkg::FreqThousand;
              end
            end
          end
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/ccd_queue.sv =====
`default_nettype none

module ccd_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ccd_pkg::cmd_t data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output ccd_pkg::cmd_t      data_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = (ccd_pkg::QueueDepth > 1) ? $clog2(ccd_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(ccd_pkg::QueueDepth + 1);

  ccd_pkg::cmd_t entries_q [ccd_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(ccd_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(ccd_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(ccd_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ccd_back.sv =====
`default_nettype none

module ccd_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [15:0]   cfg_wdata_i,
  input  wire ccd_pkg::cmd_t head_i,
  input  wire logic          empty_i,
  output logic               pop_o,
  ccd_res_if.source          res
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_e;

  localparam int unsigned CntW = $clog2(ccd_pkg::DivSteps);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]     num_q, rem_q, rem_d, quo_q, quo_d, den_q;
  ccd_pkg::cmd_t   cmd_q, sel_cmd;
  logic [5:0]      pin_q, pin_d, run_q, run_d;
  logic            fm_q, fm_d;
  ccd_pkg::res_t   out_q, out_d;
  logic            out_valid_q;
  logic            out_free, needs_div, load;
  logic [16:0]     partial;
  logic            ge;
  logic [5:0]      mask;

  assign out_free  = !out_valid_q || res.ready;
  assign needs_div = (head_i.kind == ccd_pkg::KIND_FREQ) && (head_i.freq != '0);
  assign sel_cmd   = (state_q == ST_IDLE) ? head_i : cmd_q;
  assign pop_o     = (state_q == ST_IDLE) && !empty_i && (needs_div || out_free);
  assign load      = ((state_q == ST_IDLE) && !empty_i && !needs_div && out_free) ||
                     ((state_q == ST_DONE) && out_free);

  // One restoring division step: shift in the next numerator bit, subtract if it fits.
  assign partial = {rem_q, quo_q[15]};
  assign ge      = partial >= {1'b0, den_q};
  assign rem_d   = ge ? 16'(partial - {1'b0, den_q}) : partial[15:0];
  assign quo_d   = {quo_q[14:0], ge};

  always_comb begin
    mask  = 6'(1) << sel_cmd.chan;
    pin_d = pin_q;
    run_d = run_q;
    fm_d  = fm_q;
    out_d = '0;
    case (sel_cmd.kind)
      ccd_pkg::KIND_LEVEL: begin
        pin_d             = pin_q & ~mask;
        out_d.pot_write   = 1'b1;
        out_d.pot_channel = sel_cmd.chan;
        out_d.pot_value   = sel_cmd.pot_value;
      end
      ccd_pkg::KIND_CH_OFF: begin
        pin_d = pin_q | mask;
        run_d = run_q & ~mask;
      end
      ccd_pkg::KIND_CH_ON: begin
        pin_d = pin_q & ~mask;
        if (fm_q) begin
          run_d               = run_q | mask;
          out_d.counter_clear = mask;
        end else begin
          run_d = run_q & ~mask;
        end
      end
      ccd_pkg::KIND_ALL_OFF: begin
        pin_d = ccd_pkg::AllPins;
        run_d = '0;
      end
      ccd_pkg::KIND_FREQ_ZERO: begin
        pin_d = pin_q & ~mask;
        run_d = run_q & ~mask;
        fm_d  = 1'b0;
      end
      ccd_pkg::KIND_FREQ: begin
        run_d                = run_q | mask;
        fm_d                 = 1'b1;
        out_d.counter_clear  = mask;
        out_d.period_write   = 1'b1;
        out_d.period_channel = sel_cmd.chan;
        out_d.period_value   = (sel_cmd.freq == '0) ? ccd_pkg::PeriodMax : quo_q;
      end
      default: begin
        out_d.pot_write = 1'b0;
      end
    endcase
    out_d.pin_levels     = pin_d;
    out_d.timer_running  = run_d;
    out_d.frequency_mode = fm_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_o && needs_div) begin
          state_d = ST_DIV;
          cnt_d   = '0;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(ccd_pkg::DivSteps - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      num_q       <= ccd_pkg::NumeratorReset;
      rem_q       <= '0;
      quo_q       <= '0;
      den_q       <= '0;
      cmd_q       <= '0;
      pin_q       <= ccd_pkg::AllPins;
      run_q       <= '0;
      fm_q        <= 1'b0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        num_q <= cfg_wdata_i;
      end
      if (pop_o && needs_div) begin
        cmd_q <= head_i;
        den_q <= head_i.freq;
        rem_q <= '0;
        quo_q <= num_q;
      end else if (state_q == ST_DIV) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
      end
      if (load) begin
        pin_q       <= pin_d;
        run_q       <= run_d;
        fm_q        <= fm_d;
        out_q       <= out_d;
        out_valid_q <= 1'b1;
      end else if (res.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res.valid          = out_valid_q;
  assign res.pin_levels     = out_q.pin_levels;
  assign res.timer_running  = out_q.timer_running;
  assign res.frequency_mode = out_q.frequency_mode;
  assign res.pot_write      = out_q.pot_write;
  assign res.pot_channel    = out_q.pot_channel;
  assign res.pot_value      = out_q.pot_value;
  assign res.period_write   = out_q.period_write;
  assign res.period_channel = out_q.period_channel;
  assign res.period_value   = out_q.period_value;
  assign res.counter_clear  = out_q.counter_clear;

endmodule

`default_nettype wire

// ===== rtl/channel_command_decoder.sv =====
// Channel      Direction  Handshake      Content
// cmd_i        in         valid/ready    operation and five argument bytes
// res_o        out        valid/ready    pin levels, run flags and write requests
// cfg_we_i     in         write enable   period numerator in cfg_wdata_i
//
// An item passes the combinational decoding front into a two-entry queue.
// The back end loads a switch or level item straight into its result register;
// a frequency item with a nonzero frequency first passes the 16-step shift-subtract
// period divider. Reset turns every channel off, clears run flags and frequency
// mode, and loads a numerator of 10000. A stalled result register holds the back
// end, while the queue lets the front keep taking items until it fills.
`default_nettype none

module channel_command_decoder #(
  parameter int unsigned CHANNELS = ccd_pkg::Channels
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  ccd_cmd_if.sink          cmd_i,
  ccd_res_if.source        res_o
);

  ccd_pkg::cmd_t front_cmd, head_cmd;
  logic          push, full, pop, empty;

  ccd_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .cmd    (cmd_i),
    .full_i (full),
    .cmd_o  (front_cmd),
    .push_o (push)
  );

  ccd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .empty_o (empty)
  );

  ccd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head_cmd),
    .empty_i     (empty),
    .pop_o       (pop),
    .res         (res_o)
  );

endmodule

`default_nettype wire

// ===== sim/channel_command_decoder_tb.sv =====
module channel_command_decoder_tb;
  import ccd_pkg::*;

  localparam int unsigned TimeoutCycles = 500000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned IdlePercent = 26;
  localparam int unsigned PhaseItems = 270;
  localparam int unsigned PrintLimit = 60;

  localparam logic [7:0] LevelFirst = 8'h01;
  localparam logic [7:0] LevelLast = 8'(Channels);
  localparam logic [7:0] SubOffFirst = 8'h01;
  localparam logic [7:0] SubOffLast = 8'(Channels);
  localparam logic [7:0] SubOnFirst = 8'ha1;
  localparam logic [7:0] SubOnLast = SubOnFirst + 8'(Channels) - 8'd1;
  localparam logic [7:0] OpNone = 8'h00;
  localparam logic [7:0] OpAllOnes = 8'hff;
  localparam logic [7:0] OpBeyondLevel = LevelLast + 8'd1;
  localparam logic [7:0] OpFreqBeyond = FreqLast + FreqStep;
  localparam logic [7:0] OpFreqOdd = FreqStep + 8'd1;
  localparam logic [7:0] SubNone = 8'h00;
  localparam logic [7:0] SubOnBelow = SubOnFirst - 8'd1;
  localparam logic [7:0] SubOnBeyond = SubOnLast + 8'd1;

  typedef struct packed {
    logic [7:0] operation;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
  } cmd_bytes_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  bit          gaps_on = 1'b1;
  int unsigned mismatch_count = 0;

  logic [5:0]  enable_pins;
  logic [5:0]  timers_on;
  logic        in_freq_mode;
  logic [15:0] numerator;
  res_t        expected_results[$];

  ccd_cmd_if cmd_bus ();
  ccd_res_if res_bus ();

  channel_command_decoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_bus),
    .res_o       (res_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(TimeoutCycles * 4);
    $display("TEST FAILED");
    $finish;
  end

  function automatic res_t predict_result(input cmd_bytes_t c);
    res_t        r;
    logic [2:0]  ch;
    logic [15:0] d1;
    logic [15:0] d2;
    logic [15:0] d3;
    logic [15:0] freq;
    r = '0;
    d1 = 16'(c.byte1) - 16'(Digit0);
    d2 = 16'(c.byte2) - 16'(Digit0);
    d3 = 16'(c.byte3) - 16'(Digit0);
    if (c.operation >= LevelFirst && c.operation <= LevelLast) begin
      ch = 3'(c.operation - LevelFirst);
      enable_pins[ch] = 1'b0;
      r.pot_write = 1'b1;
      r.pot_channel = ch;
      r.pot_value = LevelBase - {c.byte1[6:0], 1'b0};
    end else if (c.operation == SwitchOp) begin
      if (c.byte1 >= SubOffFirst && c.byte1 <= SubOffLast) begin
        ch = 3'(c.byte1 - SubOffFirst);
        enable_pins[ch] = 1'b1;
        timers_on[ch] = 1'b0;
      end else if (c.byte1 >= SubOnFirst && c.byte1 <= SubOnLast) begin
        ch = 3'(c.byte1 - SubOnFirst);
        enable_pins[ch] = 1'b0;
        if (in_freq_mode) begin
          timers_on[ch] = 1'b1;
          r.counter_clear[ch] = 1'b1;
        end else begin
          timers_on[ch] = 1'b0;
        end
      end else if (c.byte1 == SubAllOff) begin
        enable_pins = AllPins;
        timers_on = '0;
      end
    end else if (c.operation[3:0] == 4'd0 && c.operation >= FreqStep &&
                 c.operation <= FreqLast) begin
      ch = 3'(c.operation[7:4] - 4'd1);
      if (c.byte1 == Digit0) begin
        enable_pins[ch] = 1'b0;
        timers_on[ch] = 1'b0;
        in_freq_mode = 1'b0;
      end else begin
        if (c.byte2 == Term) begin
          freq = d1;
        end else if (c.byte3 == Term) begin
          freq = d1 * 16'd10 + d2;
        end else if (c.byte4 == Term) begin
          freq = d1 * 16'd100 + d2 * 16'd10 + d3;
        end else if (c.byte5 == Term) begin
          freq = FreqThousand;
        end else begin
          freq = FreqDefault;
        end
        r.period_write = 1'b1;
        r.period_channel = ch;
        r.period_value = (freq == 16'd0) ? PeriodMax : numerator / freq;
        timers_on[ch] = 1'b1;
        r.counter_clear[ch] = 1'b1;
        in_freq_mode = 1'b1;
      end
    end
    r.pin_levels = enable_pins;
    r.timer_running = timers_on;
    r.frequency_mode = in_freq_mode;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < PrintLimit) begin
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input int unsigned got,
                             input int unsigned want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  always @(negedge clk_i) begin
    res_bus.ready = !gaps_on || ($urandom_range(99) >= IdlePercent);
  end

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_results.pop_front();
        check_field("pin_levels", res_bus.pin_levels, want.pin_levels);
        check_field("timer_running", res_bus.timer_running, want.timer_running);
        check_field("frequency_mode", res_bus.frequency_mode, want.frequency_mode);
        check_field("pot_write", res_bus.pot_write, want.pot_write);
        check_field("pot_channel", res_bus.pot_channel, want.pot_channel);
        check_field("pot_value", res_bus.pot_value, want.pot_value);
        check_field("period_write", res_bus.period_write, want.period_write);
        check_field("period_channel", res_bus.period_channel, want.period_channel);
        check_field("period_value", res_bus.period_value, want.period_value);
        check_field("counter_clear", res_bus.counter_clear, want.counter_clear);
      end
    end
  end

  // Every task starts and returns at a falling edge. After an item is taken,
  // valid stays high so that the next item can follow without a gap.
  task automatic send_command(input logic [7:0] op, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3,
                              input logic [7:0] b4, input logic [7:0] b5);
    cmd_bytes_t c;
    c = {op, b1, b2, b3, b4, b5};
    while (gaps_on && $urandom_range(99) < IdlePercent) begin
      cmd_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    cmd_bus.valid = 1'b1;
    cmd_bus.operation = op;
    cmd_bus.byte1 = b1;
    cmd_bus.byte2 = b2;
    cmd_bus.byte3 = b3;
    cmd_bus.byte4 = b4;
    cmd_bus.byte5 = b5;
    do @(posedge clk_i); while (!cmd_bus.ready);
    expected_results.push_back(predict_result(c));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    cmd_bus.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_numerator(input logic [15:0] value);
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    numerator = value;
  endtask

  function automatic logic [7:0] random_digit();
    return ($urandom_range(9) == 0) ? 8'($urandom) : Digit0 + 8'($urandom_range(9));
  endfunction

  function automatic cmd_bytes_t random_command();
    cmd_bytes_t  c;
    logic [7:0]  b[1:5];
    int unsigned kind;
    int unsigned term_at;
    c.operation = 8'($urandom);
    for (int i = 1; i <= 5; i++) b[i] = 8'($urandom);
    kind = $urandom_range(99);
    if (kind < 25) begin
      c.operation = LevelFirst + 8'($urandom_range(Channels - 1));
    end else if (kind < 50) begin
      c.operation = SwitchOp;
      case ($urandom_range(9))
        0, 1, 2: b[1] = SubOffFirst + 8'($urandom_range(Channels - 1));
        3, 4, 5, 6: b[1] = SubOnFirst + 8'($urandom_range(Channels - 1));
        7: b[1] = SubAllOff;
        default: ;
      endcase
    end else if (kind < 88) begin
      c.operation = 8'(FreqStep * (1 + $urandom_range(Channels - 1)));
      term_at = $urandom_range(2, 6);
      for (int i = 1; i < term_at && i <= 5; i++) b[i] = random_digit();
      if (term_at <= 5) begin
        b[term_at] = Term;
      end
      if ($urandom_range(9) == 0) begin
        b[1] = Digit0;
      end else if (b[1] == Digit0) begin
        b[1] = Digit0 + 8'($urandom_range(1, 9));
      end
    end
    c.byte1 = b[1];
    c.byte2 = b[2];
    c.byte3 = b[3];
    c.byte4 = b[4];
    c.byte5 = b[5];
    return c;
  endfunction

  task automatic test_levels();
    send_command(LevelFirst, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_command(LevelLast, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_command(LevelFirst + 8'd2, 8'd90, Term, Term, Term, Term);
  endtask

  task automatic test_switching();
    send_command(SwitchOp, SubOnFirst, 8'h00, 8'h00, 8'h00, 8'h00);
    send_command(SwitchOp, SubOffFirst, 8'h00, 8'h00, 8'h00, 8'h00);
    send_command(SwitchOp, SubOffLast, 8'hff, 8'hff, 8'hff, 8'hff);
    send_command(SwitchOp, SubAllOff, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_frequency();
    send_command(FreqStep, Digit0 + 8'd5, Term, 8'h00, 8'h00, 8'h00);
    send_command(8'(FreqStep * 2), Digit0 + 8'd4, Digit0 + 8'd2, Term, 8'h00, 8'h00);
    send_command(8'(FreqStep * 3), Digit0 + 8'd9, Digit0 + 8'd9, Digit0 + 8'd9, Term,
                 8'hff);
    send_command(8'(FreqStep * 4), Digit0 + 8'd7, Digit0 + 8'd7, Digit0 + 8'd7,
                 Digit0 + 8'd7, Term);
    send_command(FreqLast, Digit0 + 8'd1, Digit0 + 8'd2, Digit0 + 8'd3, Digit0 + 8'd4,
                 Digit0 + 8'd5);
    // Ten minus ten wraps the frequency to zero.
    send_command(8'(FreqStep * 5), Digit0 + 8'd1, Digit0 - 8'd10, Term, 8'h00, 8'h00);
    send_command(SwitchOp, SubOnLast, 8'h00, 8'h00, 8'h00, 8'h00);
    send_command(FreqStep, Digit0, Term, 8'h00, 8'h00, 8'h00);
    send_command(SwitchOp, SubOnFirst + 8'd1, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_unknown_codes();
    send_command(OpNone, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_command(OpAllOnes, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_command(OpBeyondLevel, 8'h12, Term, Term, Term, Term);
    send_command(OpFreqBeyond, Digit0 + 8'd3, Term, 8'h00, 8'h00, 8'h00);
    send_command(OpFreqOdd, Digit0 + 8'd3, Term, 8'h00, 8'h00, 8'h00);
    send_command(SwitchOp, SubNone, 8'h00, 8'h00, 8'h00, 8'h00);
    send_command(SwitchOp, SubOnBeyond, 8'h00, 8'h00, 8'h00, 8'h00);
    send_command(SwitchOp, SubOnBelow, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_numerator_extremes();
    logic [15:0] values[3];
    values = '{16'd0, 16'd1, 16'hffff};
    foreach (values[i]) begin
      drain_results();
      write_numerator(values[i]);
      send_command(FreqStep, Digit0 + 8'd1, Term, 8'h00, 8'h00, 8'h00);
      send_command(FreqLast, Digit0 + 8'd9, Digit0 + 8'd9, Digit0 + 8'd9, Term, 8'h00);
    end
  endtask

  // Each phase starts from an idle block with a new numerator. One phase runs
  // with no idling on either side.
  task automatic test_random_traffic();
    cmd_bytes_t  c;
    logic [15:0] settings[5];
    settings = '{16'd1, 16'hffff, 16'd0, 16'd0, NumeratorReset};
    settings[2] = 16'($urandom);
    for (int p = 0; p < 5; p++) begin
      drain_results();
      write_numerator(settings[p]);
      gaps_on = (p != 3);
      for (int n = 0; n < PhaseItems; n++) begin
        c = random_command();
        send_command(c.operation, c.byte1, c.byte2, c.byte3, c.byte4, c.byte5);
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    cmd_bus.valid = 1'b0;
    cmd_bus.operation = '0;
    cmd_bus.byte1 = '0;
    cmd_bus.byte2 = '0;
    cmd_bus.byte3 = '0;
    cmd_bus.byte4 = '0;
    cmd_bus.byte5 = '0;
    res_bus.ready = 1'b0;
    enable_pins = AllPins;
    timers_on = '0;
    in_freq_mode = 1'b0;
    numerator = NumeratorReset;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_levels();
    test_switching();
    test_frequency();
    test_unknown_codes();
    test_numerator_extremes();
    test_random_traffic();

    drain_results();
    repeat (SettleCycles) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ccd_pkg.sv
rtl/ccd_cmd_if.sv
rtl/ccd_res_if.sv
rtl/ccd_front.sv
rtl/ccd_queue.sv
rtl/ccd_back.sv
rtl/channel_command_decoder.sv
sim/channel_command_decoder_tb.sv
